>>> rtl/core/brpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brpd_pkg
// shared types and constants of the bilevel row prefix decoder
// ----------------------------------------------------------------------------
package brpd_pkg;

    localparam int unsigned WIDTH_W        = 16;
    localparam logic [WIDTH_W-1:0] PPR_RESET = 16'd640;
    localparam int unsigned IN_DEPTH_DEF   = 2;
    localparam int unsigned OUT_DEPTH_DEF  = 2;

    localparam logic [WIDTH_W-1:0] RUN_LONG  = 16'd4;
    localparam logic [WIDTH_W-1:0] RUN_SHORT = 16'd1;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_SHORT  = 2'd1;
    localparam logic [1:0] STATUS_EXCESS = 2'd2;

    localparam logic COLOR_WHITE = 1'b0;
    localparam logic COLOR_BLACK = 1'b1;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       row_last;
        logic       row_empty;
    } in_t;

    typedef struct packed {
        logic               pixel_black;
        logic [WIDTH_W-1:0] run_length;
        logic               row_end;
        logic [1:0]         row_status;
    } res_t;

    typedef enum logic {
        CMD_CODED,
        CMD_EMPTY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] code_byte;
        logic       row_last;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BITS,
        BK_FILL,
        BK_MARK
    } bk_state_t;

endpackage

>>> rtl/core/brpd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brpd_fifo
// small register queue, first word falls through to the read port
// ----------------------------------------------------------------------------
module brpd_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_MAX);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/core/brpd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brpd_front
// accepts input words, classifies them and queues them as commands
// ----------------------------------------------------------------------------
module brpd_front
    import brpd_pkg::*;
#(
    parameter int unsigned DEPTH = IN_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  in_t  in_word,
    output logic full,
    input  logic cmd_pop,
    output cmd_t cmd,
    output logic cmd_valid
);

    cmd_t       cmd_in;
    logic       q_empty;
    logic [$bits(cmd_t)-1:0] q_rd;

    // empty row marks the byte as don't care
    always_comb
    begin
        cmd_in.kind      = in_word.row_empty ? CMD_EMPTY : CMD_CODED;
        cmd_in.code_byte = in_word.code_byte;
        cmd_in.row_last  = in_word.row_last;
    end

    brpd_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cmd_in),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (q_rd),
        .empty   (q_empty)
    );

    assign cmd       = cmd_t'(q_rd);
    assign cmd_valid = !q_empty;

endmodule

>>> rtl/core/brpd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brpd_back
// bit-serial prefix decoder, one code bit per cycle while the result queue has room, emits runs and markers
// ----------------------------------------------------------------------------
module brpd_back
    import brpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [WIDTH_W-1:0] pixels_per_row,
    input  cmd_t               cmd,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    output res_t               res,
    output logic               res_push,
    input  logic               res_full
);

    bk_state_t          state_reg, state_next;
    logic [7:0]         byte_reg, byte_next;
    logic [2:0]         bit_cnt_reg, bit_cnt_next;
    logic               last_reg, last_next;
    logic [1:0]         plen_reg, plen_next;
    logic [WIDTH_W-1:0] emitted_reg, emitted_next;
    logic               full_reg, full_next;
    logic               excess_reg, excess_next;

    logic               cur_bit;
    logic               emit;
    logic               run_color;
    logic [WIDTH_W-1:0] run_want;
    logic [WIDTH_W:0]   room;
    logic [WIDTH_W-1:0] run_len;
    logic [WIDTH_W-1:0] emitted_add;
    logic               full_now;
    logic [1:0]         status;

    assign cur_bit  = byte_reg[0];
    assign room     = {1'b0, pixels_per_row} - {1'b0, emitted_reg};
    assign full_now = full_reg || (emitted_reg >= pixels_per_row);

    // clip against remaining width
    assign run_len     = (room < {1'b0, run_want}) ? room[WIDTH_W-1:0] : run_want;
    assign emitted_add = emitted_reg + run_len;

    always_comb
    begin
        if (excess_reg)
        begin
            status = STATUS_EXCESS;
        end
        else if (emitted_reg < pixels_per_row)
        begin
            status = STATUS_SHORT;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    // code decode for the current bit
    always_comb
    begin
        emit      = 1'b0;
        run_color = COLOR_WHITE;
        run_want  = RUN_LONG;
        unique case (plen_reg)
            2'd0:
            begin
                emit      = !cur_bit;
                run_color = COLOR_WHITE;
                run_want  = RUN_LONG;
            end
            2'd1:
            begin
                emit      = !cur_bit;
                run_color = COLOR_BLACK;
                run_want  = RUN_LONG;
            end
            default:
            begin
                emit      = 1'b1;
                run_color = cur_bit;
                run_want  = RUN_SHORT;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        byte_next    = byte_reg;
        bit_cnt_next = bit_cnt_reg;
        last_next    = last_reg;
        plen_next    = plen_reg;
        emitted_next = emitted_reg;
        full_next    = full_reg;
        excess_next  = excess_reg;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        res          = '0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == CMD_EMPTY)
                    begin
                        // abandon any row in progress
                        plen_next    = '0;
                        emitted_next = '0;
                        full_next    = 1'b0;
                        excess_next  = 1'b0;
                        state_next   = (pixels_per_row != '0) ? BK_FILL : BK_MARK;
                    end
                    else if (full_now)
                    begin
                        full_next   = 1'b1;
                        excess_next = 1'b1;
                        state_next  = cmd.row_last ? BK_MARK : BK_IDLE;
                    end
                    else
                    begin
                        byte_next    = cmd.code_byte;
                        bit_cnt_next = '0;
                        last_next    = cmd.row_last;
                        state_next   = BK_BITS;
                    end
                end
            end

            BK_FILL:
            begin
                if (!res_full)
                begin
                    res_push         = 1'b1;
                    res.pixel_black  = COLOR_WHITE;
                    res.run_length   = pixels_per_row;
                    emitted_next     = pixels_per_row;
                    full_next        = 1'b1;
                    state_next       = BK_MARK;
                end
            end

            BK_BITS:
            begin
                if (!(emit && res_full))
                begin
                    res_push        = emit;
                    res.pixel_black = run_color;
                    res.run_length  = run_len;
                    if (emit)
                    begin
                        emitted_next = emitted_add;
                        full_next    = (emitted_add >= pixels_per_row);
                        plen_next    = '0;
                    end
                    else
                    begin
                        plen_next = plen_reg + 2'd1;
                    end
                    byte_next    = {1'b0, byte_reg[7:1]};
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    if (full_next || (bit_cnt_reg == 3'd7))
                    begin
                        if (full_next)
                        begin
                            plen_next = '0;
                        end
                        state_next = last_reg ? BK_MARK : BK_IDLE;
                    end
                end
            end

            BK_MARK:
            begin
                if (!res_full)
                begin
                    res_push       = 1'b1;
                    res.row_end    = 1'b1;
                    res.row_status = status;
                    plen_next      = '0;
                    emitted_next   = '0;
                    full_next      = 1'b0;
                    excess_next    = 1'b0;
                    state_next     = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            plen_reg    <= '0;
            emitted_reg <= '0;
            full_reg    <= 1'b0;
            excess_reg  <= 1'b0;
            last_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            plen_reg    <= plen_next;
            emitted_reg <= emitted_next;
            full_reg    <= full_next;
            excess_reg  <= excess_next;
            last_reg    <= last_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

>>> rtl/core/bilevel_row_prefix_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilevel_row_prefix_decoder_core
// decodes prefix-coded bilevel rows into color runs with an end-of-row marker
// ----------------------------------------------------------------------------
// Each coded byte is pushed as one word and read lsb first as a prefix code
// (0: 4 white, 10: 4 black, 110: 1 white, 111: 1 black); every finished code
// pops out as one run word, clipped at pixels_per_row, and the last byte of a
// row (or an empty-row word, after a white run of the whole nonzero width)
// adds a marker word with status ok, short or excess. The bit-serial engine
// takes a coded byte when idle and decodes one bit per cycle while the result
// queue has room, until the byte ends or the row fills, then sends any marker.
// Input and result queues decouple both sides, so words keep coming in while
// runs wait to be popped, until the input queue fills. pixels_per_row resets
// to 640 and should only be written while the block has gone quiet.
// ----------------------------------------------------------------------------
module bilevel_row_prefix_decoder_core
    import brpd_pkg::*;
#(
    parameter int unsigned IN_DEPTH  = IN_DEPTH_DEF,
    parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // input word queue side
    input  logic               push,
    input  in_t                in_word,
    output logic               full,
    // result word queue side
    input  logic               pop,
    output res_t               out_word,
    output logic               empty,
    // width register write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WIDTH_W-1:0] cfg_data
);

    logic [WIDTH_W-1:0] ppr_reg;

    cmd_t  cmd;
    logic  cmd_valid;
    logic  cmd_pop;
    res_t  res;
    logic  res_push;
    logic  res_full;
    logic [$bits(res_t)-1:0] out_raw;

    // width register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppr_reg <= PPR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ppr_reg <= cfg_data;
        end
    end

    // front: accept and classify
    brpd_front #(
        .DEPTH (IN_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_word   (in_word),
        .full      (full),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_valid (cmd_valid)
    );

    // back: bit-serial decode
    brpd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixels_per_row (ppr_reg),
        .cmd            (cmd),
        .cmd_valid      (cmd_valid),
        .cmd_pop        (cmd_pop),
        .res            (res),
        .res_push       (res_push),
        .res_full       (res_full)
    );

    // result queue, head word is presented on out_word
    brpd_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (out_raw),
        .empty   (empty)
    );

    assign out_word = res_t'(out_raw);

endmodule
